// File: src/resize_shear_nearest_warp_unit_macros.svh
// assertion helpers for the warp unit
`ifndef RESIZE_SHEAR_NEAREST_WARP_UNIT_MACROS_SVH
`define RESIZE_SHEAR_NEAREST_WARP_UNIT_MACROS_SVH

// property that holds at every edge outside reset
`define RSNW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define RSNW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rsnw_pkg.sv
package rsnw_pkg;

  // frame store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int FRAME_DEPTH = 2 ** ADDR_W;

  // quotient bits: enough to tell any coordinate inside the store
  localparam int Q_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  // numerator after scaling by the source size, and twice the |det|
  localparam int NUM_W = 38;
  localparam int DEN_W = 26;
  localparam int REM_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
  // compare width for quotient against size registers
  localparam int CMP_W = ((Q_W > 9) ? Q_W : 9) + 1;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_SCALED_WIDTH  = 3'd2,
    CFG_SCALED_HEIGHT = 3'd3,
    CFG_SHEAR_X       = 3'd4,
    CFG_SHEAR_Y       = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [12:0] coord_x;
    logic [12:0] coord_y;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        in_range;
  } out_item_t;

  // item bookkeeping that rides along the pipeline
  typedef struct packed {
    logic              cmd;
    logic              wr_ok;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       pixel;
  } ctl_t;

  // restoring divider state for one axis
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } div_t;

  // one quotient bit of restoring division
  function automatic div_t div_step(div_t s, logic [DEN_W-1:0] den, int bitpos);
    logic [REM_W-1:0] trial;
    div_t             r;
    trial = REM_W'(den) << bitpos;
    r     = s;
    if (s.rem >= trial) begin
      r.rem         = s.rem - trial;
      r.quo[bitpos] = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: src/resize_shear_nearest_warp_unit.sv
// items pass offset, product, sum, scaling and set-up stages, then the restoring divider
// throughput: one item per cycle unless a held result stalls; one quotient bit per stage
// writes and samples share the pipeline so the frame read sees every earlier write
// reset: asynchronous, active low; clears valid bits and loads the size and shear defaults
// frame store content is undefined after reset until written
`include "resize_shear_nearest_warp_unit_macros.svh"

module resize_shear_nearest_warp_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rsnw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsnw_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i
);
  import rsnw_pkg::*;

  localparam int LAST = 4 + Q_W;

  // configuration
  logic [8:0]         sw_q, sh_q;
  logic [11:0]        nw_q, nh_q;
  logic signed [12:0] ox_q, oy_q;

  // pipeline control
  logic            adv;
  logic [LAST:0]   vld_q;
  ctl_t            ctl_q [0:LAST];
  logic            res_vld_q, res_ok_q;

  // arithmetic stages
  logic signed [13:0] dx_q, dy_q, xs, ys, dx_d, dy_d;
  logic signed [26:0] pa_q, pb_q, pc_q, pd_q;
  logic [23:0]        pe_q;
  logic signed [25:0] pf_q;
  logic signed [27:0] numx_q, numy_q;
  logic signed [26:0] det2_q, det3_q;
  logic signed [NUM_W-1:0] nx_q, ny_q;

  // divider
  div_t             divx_q [0:Q_W];
  div_t             divy_q [0:Q_W];
  logic [DEN_W-1:0] den_q  [0:Q_W];
  logic [Q_W:0]     dz_q;
  logic [NUM_W-2:0] ax, ay;
  logic [24:0]      ad;
  logic [REM_W-1:0] numer_x, numer_y, den_lim;
  logic [DEN_W-1:0] den_d;

  // frame access
  logic              okx, oky, ok_fin;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_rdata;
  ctl_t              fin;

  assign cfg_ready_o = 1'b1;
  assign adv         = !res_vld_q || out_ready_i;
  assign in_ready_o  = adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 9'd256;
      sh_q <= 9'd256;
      nw_q <= 12'd256;
      nh_q <= 12'd256;
      ox_q <= '0;
      oy_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:     sw_q <= cfg_data_i[8:0];
        CFG_SRC_HEIGHT:    sh_q <= cfg_data_i[8:0];
        CFG_SCALED_WIDTH:  nw_q <= cfg_data_i[11:0];
        CFG_SCALED_HEIGHT: nh_q <= cfg_data_i[11:0];
        CFG_SHEAR_X:       ox_q <= $signed(cfg_data_i);
        CFG_SHEAR_Y:       oy_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
      res_ok_q  <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LAST-1:0], in_valid_i};
      res_vld_q <= vld_q[LAST] && (fin.cmd == CMD_SAMPLE);
      res_ok_q  <= ok_fin;
    end
  end

  // offsets relative to the sheared origin
  always_comb begin
    xs   = $signed({1'b0, in_data_i.coord_x});
    ys   = $signed({1'b0, in_data_i.coord_y});
    dx_d = ox_q[12] ? xs : xs - 14'(ox_q);
    dy_d = oy_q[12] ? ys + 14'(oy_q) : ys;
  end

  // bookkeeping shift line
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0].cmd   <= in_data_i.cmd;
      ctl_q[0].wr_ok <= (14'(in_data_i.coord_x) < 14'(MAX_WIDTH))
                     && (14'(in_data_i.coord_y) < 14'(MAX_HEIGHT));
      ctl_q[0].waddr <= {in_data_i.coord_y[ROW_W-1:0], in_data_i.coord_x[COL_W-1:0]};
      ctl_q[0].pixel <= in_data_i.pixel_in;
      for (int i = 1; i <= LAST; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // stages one to four: offsets, products, sums, scaling by source size
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      pa_q   <= 27'(dx_q) * 27'($signed({1'b0, nh_q}));
      pb_q   <= dy_q * 27'(ox_q);
      pc_q   <= 27'($signed({1'b0, nw_q})) * 27'(dy_q);
      pd_q   <= 27'(oy_q) * dx_q;
      pe_q   <= 24'(nw_q) * 24'(nh_q);
      pf_q   <= 26'(ox_q) * 26'(oy_q);
      numx_q <= 28'(pa_q) + 28'(pb_q);
      numy_q <= 28'(pc_q) - 28'(pd_q);
      det2_q <= $signed({3'b000, pe_q}) + 27'(pf_q);
      nx_q   <= NUM_W'(numx_q) * $signed({1'b0, sw_q});
      ny_q   <= NUM_W'(numy_q) * $signed({1'b0, sh_q});
      det3_q <= det2_q;
    end
  end

  // divider set-up: magnitudes, rounding bias, overflow of the quotient
  always_comb begin
    ax      = nx_q[NUM_W-1] ? (NUM_W-1)'(-nx_q) : (NUM_W-1)'(nx_q);
    ay      = ny_q[NUM_W-1] ? (NUM_W-1)'(-ny_q) : (NUM_W-1)'(ny_q);
    ad      = det3_q[26] ? 25'(-det3_q) : 25'(det3_q);
    den_d   = {ad, 1'b0};
    numer_x = (REM_W'(ax) << 1) + REM_W'(ad);
    numer_y = (REM_W'(ay) << 1) + REM_W'(ad);
    den_lim = REM_W'(den_d) << Q_W;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      divx_q[0] <= '{rem: numer_x, quo: '0, neg: nx_q[NUM_W-1] ^ det3_q[26],
                     ovf: numer_x >= den_lim};
      divy_q[0] <= '{rem: numer_y, quo: '0, neg: ny_q[NUM_W-1] ^ det3_q[26],
                     ovf: numer_y >= den_lim};
      den_q[0]  <= den_d;
      dz_q[0]   <= (det3_q == '0);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    div_t step_x, step_y;
    always_comb begin
      step_x = div_step(divx_q[k], den_q[k], Q_W - 1 - k);
      step_y = div_step(divy_q[k], den_q[k], Q_W - 1 - k);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        divx_q[k+1] <= step_x;
        divy_q[k+1] <= step_y;
        den_q[k+1]  <= den_q[k];
        dz_q[k+1]   <= dz_q[k];
      end
    end
  end

  // range check on the mapped coordinate
  always_comb begin
    fin = ctl_q[LAST];
    okx = !divx_q[Q_W].ovf && !(divx_q[Q_W].neg && (|divx_q[Q_W].quo))
       && (CMP_W'(divx_q[Q_W].quo) < CMP_W'(sw_q))
       && (CMP_W'(divx_q[Q_W].quo) < CMP_W'(MAX_WIDTH));
    oky = !divy_q[Q_W].ovf && !(divy_q[Q_W].neg && (|divy_q[Q_W].quo))
       && (CMP_W'(divy_q[Q_W].quo) < CMP_W'(sh_q))
       && (CMP_W'(divy_q[Q_W].quo) < CMP_W'(MAX_HEIGHT));
    ok_fin = !dz_q[Q_W] && okx && oky;
  end

  // frame store port: writes and sample reads in item order
  always_comb begin
    ram_we   = (fin.cmd == CMD_WRITE);
    ram_en   = adv && vld_q[LAST] && (ram_we ? fin.wr_ok : 1'b1);
    ram_addr = ram_we ? fin.waddr
                      : {divy_q[Q_W].quo[ROW_W-1:0], divx_q[Q_W].quo[COL_W-1:0]};
  end

  rsnw_ram #(
    .WIDTH (32),
    .DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (fin.pixel),
    .rdata_o (ram_rdata)
  );

  // result
  assign out_valid_o          = res_vld_q;
  assign out_data_o.in_range  = res_ok_q;
  assign out_data_o.pixel_out = res_ok_q ? ram_rdata : '0;

  `RSNW_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_q) && $stable(res_vld_q), "pipeline moved during stall")
  `RSNW_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0], "accepted item not in first stage")
  `RSNW_ASSERT(a_rem_below_den, vld_q[LAST] && !divx_q[Q_W].ovf |-> divx_q[Q_W].rem < REM_W'(den_q[Q_W]), "divider remainder not reduced")

endmodule

// File: src/rsnw_ram.sv
module rsnw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, read data registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
